// File: hdl/sapid_pkg.sv
// ----------------------------------------------------------------------------
// sapid_pkg
// Shared constants, operation codes and the controller command bundle for
// the servo angle PID step core.
// ----------------------------------------------------------------------------
package sapid_pkg;

  // Reading and angle mapping
  localparam int ADC_WIDTH = 12;
  localparam logic [ADC_WIDTH-1:0] ADC_LO = ADC_WIDTH'(330);
  localparam logic [ADC_WIDTH-1:0] ADC_HI = ADC_WIDTH'(620);
  localparam int DELTA_W = 9;   // clamped reading minus low limit: 0..290
  localparam int NUM_W   = 23;  // delta * 23040 + 145
  localparam logic [NUM_W-1:0] ANGLE_SPAN = NUM_W'(23040);
  localparam logic [NUM_W-1:0] ADC_ROUND  = NUM_W'(145);
  localparam logic signed [15:0] ANGLE_LIM  = 16'sd11520;
  localparam logic signed [14:0] TARGET_MAX = 15'sd11520;
  localparam logic signed [14:0] TARGET_MIN = -15'sd11520;

  // Reciprocals scaled by 2^32, exact over the operand ranges used here
  localparam logic signed [31:0] RECIP_290 = 32'sd14810233;
  localparam logic signed [31:0] RECIP_100 = 32'sd42949673;
  localparam logic signed [23:0] INTERVAL_MS = 24'sd100;

  localparam logic signed [32:0] INT32_MAX_X = 33'sd2147483647;
  localparam logic signed [32:0] INT32_MIN_X = -33'sd2147483648;
  localparam logic signed [48:0] DRIVE_MAX_X = 49'sd32767;
  localparam logic signed [48:0] DRIVE_MIN_X = -49'sd32768;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd4;

  // Shared multiplier operand selection
  localparam logic [2:0] MUL_NONE  = 3'd0;
  localparam logic [2:0] MUL_ANGLE = 3'd1;
  localparam logic [2:0] MUL_KP    = 3'd2;
  localparam logic [2:0] MUL_DIV   = 3'd3;
  localparam logic [2:0] MUL_KI    = 3'd4;
  localparam logic [2:0] MUL_KD    = 3'd5;

  // Accumulator operations
  localparam logic [1:0] ACC_HOLD   = 2'd0;
  localparam logic [1:0] ACC_LOAD   = 2'd1;
  localparam logic [1:0] ACC_ADD    = 2'd2;
  localparam logic [1:0] ACC_ADD_SH = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic [2:0] mul_sel;
    logic       ld_err;
    logic       ld_integ;
    logic       ld_deriv;
    logic [1:0] acc_op;
    logic       ld_out;
  } sapid_cmd_t;

endpackage

// File: hdl/sapid_ctrl.sv
// ----------------------------------------------------------------------------
// sapid_ctrl
// Sequencer for one control tick: walks the datapath through the angle
// mapping, error, integral, derivative and gain products, and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module sapid_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sapid_pkg::sapid_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ANG   = 4'd1;
  localparam logic [3:0] ST_ERR   = 4'd2;
  localparam logic [3:0] ST_INTEG = 4'd3;
  localparam logic [3:0] ST_DIVD  = 4'd4;
  localparam logic [3:0] ST_KI    = 4'd5;
  localparam logic [3:0] ST_KD    = 4'd6;
  localparam logic [3:0] ST_ACC   = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = sapid_pkg::MUL_NONE;
    cmd.acc_op  = sapid_pkg::ACC_HOLD;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_ANG;
        end
      end
      ST_ANG: begin
        cmd.mul_sel = sapid_pkg::MUL_ANGLE;
        state_next  = ST_ERR;
      end
      ST_ERR: begin
        cmd.ld_err = 1'b1;
        state_next = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.ld_integ = 1'b1;
        cmd.mul_sel  = sapid_pkg::MUL_KP;
        state_next   = ST_DIVD;
      end
      ST_DIVD: begin
        cmd.mul_sel = sapid_pkg::MUL_DIV;
        cmd.acc_op  = sapid_pkg::ACC_LOAD;
        state_next  = ST_KI;
      end
      ST_KI: begin
        cmd.ld_deriv = 1'b1;
        cmd.mul_sel  = sapid_pkg::MUL_KI;
        state_next   = ST_KD;
      end
      ST_KD: begin
        cmd.mul_sel = sapid_pkg::MUL_KD;
        cmd.acc_op  = sapid_pkg::ACC_ADD;
        state_next  = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_op = sapid_pkg::ACC_ADD_SH;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.ld_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.ld_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_ld_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_out |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_accept_starts_tick: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_ANG))
    else $error("accepted transaction did not start a tick");

  a_acc_then_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC) |=> (state == ST_OUT))
    else $error("accumulate step not followed by output step");

  a_valid_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_OUT))
    else $error("result raised outside the output step");
`endif

endmodule

// File: hdl/sapid_dp.sv
// ----------------------------------------------------------------------------
// sapid_dp
// Datapath: configuration registers, angle mapping, error, saturating
// integral, derivative, one shared 32x32 multiplier, accumulator and the
// output register.
// ----------------------------------------------------------------------------
module sapid_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  sapid_pkg::sapid_cmd_t               cmd,
  input  logic [sapid_pkg::ADC_WIDTH-1:0]     filtered_adc,
  input  logic                                cfg_we,
  input  logic [sapid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                         cfg_data,
  output logic signed [15:0]                  drive,
  output logic signed [14:0]                  measured_angle,
  output logic signed [15:0]                  angle_error
);

  // Configuration
  logic signed [31:0] kp;
  logic signed [31:0] ki;
  logic signed [31:0] kd;
  logic signed [15:0] bias;
  logic signed [14:0] target_angle;

  // Controller state kept across ticks
  logic signed [31:0] integral_sum;
  logic signed [15:0] previous_error;

  // Per-tick working registers
  logic [sapid_pkg::ADC_WIDTH-1:0] adc;
  logic signed [14:0] angle;
  logic signed [15:0] err;
  logic [23:0]        diff_mag;
  logic               diff_neg;
  logic signed [17:0] deriv;
  logic signed [63:0] prod;
  logic signed [63:0] acc;

  // Combinational terms
  logic [sapid_pkg::ADC_WIDTH-1:0] adc_clamped;
  logic [sapid_pkg::DELTA_W-1:0]   delta;
  logic [sapid_pkg::NUM_W-1:0]     num;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [15:0] angle_wide;
  logic signed [14:0] target_clamped;
  logic signed [15:0] err_next;
  logic signed [23:0] err_x100;
  logic signed [32:0] integ_sum;
  logic signed [31:0] integ_sat;
  logic signed [16:0] diff;
  logic signed [24:0] diff_x256;
  logic signed [24:0] diff_abs;
  logic [16:0]        quot;
  logic signed [17:0] deriv_next;
  logic signed [48:0] drive_sum;
  logic signed [15:0] drive_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp           <= '0;
      ki           <= '0;
      kd           <= '0;
      bias         <= '0;
      target_angle <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sapid_pkg::REG_KP:     kp           <= cfg_data;
        sapid_pkg::REG_KI:     ki           <= cfg_data;
        sapid_pkg::REG_KD:     kd           <= cfg_data;
        sapid_pkg::REG_BIAS:   bias         <= cfg_data[15:0];
        sapid_pkg::REG_TARGET: target_angle <= cfg_data[14:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Angle: -11520 + round(delta * 23040 / 290), division by reciprocal
  always_comb begin
    if (adc < sapid_pkg::ADC_LO) begin
      adc_clamped = sapid_pkg::ADC_LO;
    end else if (adc > sapid_pkg::ADC_HI) begin
      adc_clamped = sapid_pkg::ADC_HI;
    end else begin
      adc_clamped = adc;
    end
    delta = sapid_pkg::DELTA_W'(adc_clamped - sapid_pkg::ADC_LO);
    num   = sapid_pkg::NUM_W'(delta) * sapid_pkg::ANGLE_SPAN + sapid_pkg::ADC_ROUND;
  end

  always_comb begin
    case (cmd.mul_sel)
      sapid_pkg::MUL_ANGLE: begin
        mul_a = $signed(32'(num));
        mul_b = sapid_pkg::RECIP_290;
      end
      sapid_pkg::MUL_KP: begin
        mul_a = kp;
        mul_b = 32'(err);
      end
      sapid_pkg::MUL_DIV: begin
        mul_a = $signed(32'(diff_mag));
        mul_b = sapid_pkg::RECIP_100;
      end
      sapid_pkg::MUL_KI: begin
        mul_a = ki;
        mul_b = integral_sum;
      end
      sapid_pkg::MUL_KD: begin
        mul_a = kd;
        mul_b = 32'(deriv);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    angle_wide = $signed({1'b0, prod[46:32]}) - sapid_pkg::ANGLE_LIM;
    if (target_angle > sapid_pkg::TARGET_MAX) begin
      target_clamped = sapid_pkg::TARGET_MAX;
    end else if (target_angle < sapid_pkg::TARGET_MIN) begin
      target_clamped = sapid_pkg::TARGET_MIN;
    end else begin
      target_clamped = target_angle;
    end
    err_next = 16'(target_clamped) - angle_wide;
  end

  always_comb begin
    err_x100  = 24'(err) * sapid_pkg::INTERVAL_MS;
    integ_sum = 33'(integral_sum) + 33'(err_x100);
    if (integ_sum > sapid_pkg::INT32_MAX_X) begin
      integ_sat = sapid_pkg::INT32_MAX_X[31:0];
    end else if (integ_sum < sapid_pkg::INT32_MIN_X) begin
      integ_sat = sapid_pkg::INT32_MIN_X[31:0];
    end else begin
      integ_sat = integ_sum[31:0];
    end
    diff      = 17'(err) - 17'(previous_error);
    diff_x256 = {diff, 8'b0};
    diff_abs  = diff[16] ? -diff_x256 : diff_x256;
  end

  // Truncate toward zero: divide the magnitude, then restore the sign
  always_comb begin
    quot       = prod[48:32];
    deriv_next = diff_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  end

  always_comb begin
    drive_sum = 49'($signed(acc[63:16])) + 49'(bias);
    if (drive_sum > sapid_pkg::DRIVE_MAX_X) begin
      drive_sat = sapid_pkg::DRIVE_MAX_X[15:0];
    end else if (drive_sum < sapid_pkg::DRIVE_MIN_X) begin
      drive_sat = sapid_pkg::DRIVE_MIN_X[15:0];
    end else begin
      drive_sat = drive_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
    end else if (cmd.ld_integ) begin
      integral_sum   <= integ_sat;
      previous_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.load_in) begin
      adc <= filtered_adc;
    end
    if (cmd.ld_err) begin
      angle <= angle_wide[14:0];
      err   <= err_next;
    end
    if (cmd.ld_integ) begin
      diff_mag <= diff_abs[23:0];
      diff_neg <= diff[16];
    end
    if (cmd.ld_deriv) begin
      deriv <= deriv_next;
    end
    case (cmd.acc_op)
      sapid_pkg::ACC_LOAD:   acc <= prod;
      sapid_pkg::ACC_ADD:    acc <= acc + prod;
      sapid_pkg::ACC_ADD_SH: acc <= acc + (prod >>> 8);
      default: begin
        // hold
      end
    endcase
    if (cmd.ld_out) begin
      drive          <= drive_sat;
      measured_angle <= angle;
      angle_error    <= err;
    end
  end

endmodule

// File: hdl/servo_angle_pid_step_core.sv
// ----------------------------------------------------------------------------
// servo_angle_pid_step_core
// Fixed-point servo angle PID: maps a filtered potentiometer reading to an
// angle, forms the error against the target and runs one PID step per input.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  input    in_valid/in_ready    filtered_adc
//  output   out_valid/out_ready  drive, measured_angle, angle_error
//  config   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  The sequencer issues five products through one shared 32x32 multiplier,
//  with the error, integral and accumulate steps around them, then loads the
//  output register; the next input is taken only once that step is done and
//  the sequencer is back in idle.
//  Reset (synchronous, active high) clears the gains, bias, target, the
//  integral and the previous error.
//  A waiting result does not block the next input; the last step holds only
//  while the previous result is still untaken.
//  Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module servo_angle_pid_step_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sapid_pkg::ADC_WIDTH-1:0]   filtered_adc,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [15:0]                drive,
  output logic signed [14:0]                measured_angle,
  output logic signed [15:0]                angle_error,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sapid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                       cfg_data
);

  sapid_pkg::sapid_cmd_t cmd;

  assign cfg_ready = 1'b1;

  sapid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sapid_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .filtered_adc   (filtered_adc),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .drive          (drive),
    .measured_angle (measured_angle),
    .angle_error    (angle_error)
  );

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the servo angle PID step core. A directed table of
// ticks and register writes runs first, then randomized phases of readings
// under several gain settings, including wind-up runs that hold the error at
// full scale to push the integral far one way and back. Every result is
// compared field by field against a cycle-free model of the control tick.
// ----------------------------------------------------------------------------
module testbench;

  localparam longint READ_LO    = 330;
  localparam longint READ_HI    = 620;
  localparam longint ANGLE_FULL = 11520;
  localparam longint TICK_MS    = 100;
  localparam longint SUM_MAX    = 64'sh7FFF_FFFF;
  localparam longint SUM_MIN    = -SUM_MAX - 1;
  localparam longint DRIVE_MAX  = 32767;
  localparam longint DRIVE_MIN  = -32768;
  localparam int     STALL_LIMIT = 3000;
  localparam int     HOLD_OFF    = 400;

  // indexes past the last register; writes there must change nothing
  localparam logic [sapid_pkg::CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [sapid_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [sapid_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [15:0] drive;
    logic signed [14:0] angle;
    logic signed [15:0] err;
  } tick_result_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  // idx is only meaningful on writes; typed rows carry a hand-derived result
  typedef struct packed {
    row_kind_t                       kind;
    logic [sapid_pkg::CFG_IDX_W-1:0] idx;
    logic [31:0]                     val;
    logic                            typed;
    tick_result_t                    res;
  } plan_row_t;

  typedef enum {PH_MIXED, PH_MAX, PH_MIN, PH_WIND_UP, PH_WIND_DOWN} phase_kind_t;

  localparam tick_result_t NO_RES = '0;

  localparam plan_row_t DIRECTED [38] = '{
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd0,        1'b1, '{16'sd0, -15'sd11520, 16'sd11520}},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd4095,     1'b1, '{16'sd0, 15'sd11520, -16'sd11520}},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd329,      1'b1, '{16'sd0, -15'sd11520, 16'sd11520}},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd330,      1'b1, '{16'sd0, -15'sd11520, 16'sd11520}},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd620,      1'b1, '{16'sd0, 15'sd11520, -16'sd11520}},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd621,      1'b1, '{16'sd0, 15'sd11520, -16'sd11520}},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd475,      1'b1, '{16'sd0, 15'sd0, 16'sd0}},
    '{ROW_WRITE, sapid_pkg::REG_BIAS,   32'h0000_7FFF, 1'b0, NO_RES},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd475,      1'b1, '{16'sd32767, 15'sd0, 16'sd0}},
    '{ROW_WRITE, sapid_pkg::REG_BIAS,   32'hFFFF_8000, 1'b0, NO_RES},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd475,      1'b1, '{-16'sd32768, 15'sd0, 16'sd0}},
    '{ROW_WRITE, sapid_pkg::REG_TARGET, 32'h0000_2D00, 1'b0, NO_RES},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd475,      1'b1, '{-16'sd32768, 15'sd0, 16'sd11520}},
    '{ROW_WRITE, sapid_pkg::REG_TARGET, 32'h0000_3FFF, 1'b0, NO_RES},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd620,      1'b1, '{-16'sd32768, 15'sd11520, 16'sd0}},
    '{ROW_WRITE, sapid_pkg::REG_TARGET, 32'h0000_4000, 1'b0, NO_RES},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd330,      1'b1, '{-16'sd32768, -15'sd11520, 16'sd0}},
    '{ROW_WRITE, sapid_pkg::REG_TARGET, 32'd0,        1'b0, NO_RES},
    '{ROW_WRITE, sapid_pkg::REG_BIAS,   32'd0,        1'b0, NO_RES},
    '{ROW_WRITE, sapid_pkg::REG_KP,     32'h0001_0000, 1'b0, NO_RES},
    '{ROW_WRITE, sapid_pkg::REG_KI,     32'h0000_0040, 1'b0, NO_RES},
    '{ROW_WRITE, sapid_pkg::REG_KD,     32'h0001_0000, 1'b0, NO_RES},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd331,      1'b0, NO_RES},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd619,      1'b0, NO_RES},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd476,      1'b0, NO_RES},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd474,      1'b0, NO_RES},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'h555,      1'b0, NO_RES},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'hAAA,      1'b0, NO_RES},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd400,      1'b0, NO_RES},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd550,      1'b0, NO_RES},
    '{ROW_WRITE, sapid_pkg::REG_KP,     32'h7FFF_FFFF, 1'b0, NO_RES},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd330,      1'b0, NO_RES},
    '{ROW_WRITE, sapid_pkg::REG_KP,     32'h8000_0000, 1'b0, NO_RES},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd330,      1'b0, NO_RES},
    '{ROW_WRITE, REG_SPARE_5,           32'hFFFF_FFFF, 1'b0, NO_RES},
    '{ROW_WRITE, REG_SPARE_6,           32'hFFFF_FFFF, 1'b0, NO_RES},
    '{ROW_WRITE, REG_SPARE_7,           32'hFFFF_FFFF, 1'b0, NO_RES},
    '{ROW_TICK,  sapid_pkg::REG_KP,     32'd475,      1'b0, NO_RES}
  };

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_ready;
  logic [sapid_pkg::ADC_WIDTH-1:0]     filtered_adc;
  logic                                out_valid;
  logic                                out_ready;
  logic signed [15:0]                  drive;
  logic signed [14:0]                  measured_angle;
  logic signed [15:0]                  angle_error;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [sapid_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [31:0]                         cfg_data;

  // controller model: registers and tick state
  logic signed [31:0] gain_p;
  logic signed [31:0] gain_i;
  logic signed [31:0] gain_d;
  logic signed [15:0] bias_val;
  logic signed [14:0] target_val;
  logic signed [31:0] integ_state;
  logic signed [15:0] err_state;

  tick_result_t                    pending_ticks[$];
  tick_result_t                    want;
  int                              ticks_done;
  int                              mismatch_count;
  int                              stall_cycles;
  logic [sapid_pkg::ADC_WIDTH-1:0] last_adc;

  servo_angle_pid_step_core DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .filtered_adc   (filtered_adc),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .drive          (drive),
    .measured_angle (measured_angle),
    .angle_error    (angle_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tick_result_t servo_tick(input logic [sapid_pkg::ADC_WIDTH-1:0] adc);
    longint       reading;
    longint       angle;
    longint       target;
    longint       err;
    longint       integ;
    longint       deriv;
    longint       acc;
    longint       level;
    tick_result_t res;
    reading = longint'(adc);
    if (reading < READ_LO) reading = READ_LO;
    if (reading > READ_HI) reading = READ_HI;
    // round half up onto the Q8 angle span
    angle = ((reading - READ_LO) * 2 * ANGLE_FULL + (READ_HI - READ_LO) / 2)
            / (READ_HI - READ_LO) - ANGLE_FULL;
    target = longint'(target_val);
    if (target > ANGLE_FULL) target = ANGLE_FULL;
    if (target < -ANGLE_FULL) target = -ANGLE_FULL;
    err = target - angle;
    integ = longint'(integ_state) + err * TICK_MS;
    if (integ > SUM_MAX) integ = SUM_MAX;
    if (integ < SUM_MIN) integ = SUM_MIN;
    // signed division truncates toward zero
    deriv = ((err - longint'(err_state)) * 256) / TICK_MS;
    acc = longint'(gain_p) * err + longint'(gain_i) * integ
          + ((longint'(gain_d) * deriv) >>> 8);
    level = (acc >>> 16) + longint'(bias_val);
    if (level > DRIVE_MAX) level = DRIVE_MAX;
    if (level < DRIVE_MIN) level = DRIVE_MIN;
    integ_state = integ[31:0];
    err_state   = err[15:0];
    res.drive = level[15:0];
    res.angle = angle[14:0];
    res.err   = err[15:0];
    return res;
  endfunction

  function automatic logic [31:0] rand_gain(input bit tame);
    if (tame) return 32'($urandom_range(0, 512)) - 32'd256;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      2: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      default: return 32'($urandom_range(0, 512)) - 32'd256;
    endcase
  endfunction

  function automatic logic [sapid_pkg::ADC_WIDTH-1:0] pick_adc(input phase_kind_t kind);
    int                              r;
    logic [sapid_pkg::ADC_WIDTH-1:0] a;
    r = $urandom_range(0, 99);
    case (kind)
      PH_WIND_UP:   a = (r < 85) ? 12'($urandom_range(0, 330)) : 12'($urandom);
      PH_WIND_DOWN: a = (r < 85) ? 12'($urandom_range(620, 4095)) : 12'($urandom);
      default: begin
        if (r < 45) a = 12'($urandom_range(330, 620));
        else if (r < 65) a = 12'($urandom);
        else if (r < 85) a = $urandom_range(0, 1) ? 12'($urandom_range(320, 340))
                                                  : 12'($urandom_range(610, 630));
        else a = last_adc + 12'($urandom_range(0, 16)) - 12'd8;
      end
    endcase
    last_adc = a;
    return a;
  endfunction

  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_error(input string msg);
    if (mismatch_count < 40) $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  task automatic cfg_write(input logic [sapid_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sapid_pkg::REG_KP:     gain_p = data;
      sapid_pkg::REG_KI:     gain_i = data;
      sapid_pkg::REG_KD:     gain_d = data;
      sapid_pkg::REG_BIAS:   bias_val = data[15:0];
      sapid_pkg::REG_TARGET: target_val = data[14:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_tick(input logic [sapid_pkg::ADC_WIDTH-1:0] adc, input int gap,
                           input logic typed, input tick_result_t fixed_res);
    tick_result_t predicted;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    filtered_adc = adc;
    do @(posedge clk); while (!in_ready);
    predicted = servo_tick(adc);
    pending_ticks.push_back(typed ? fixed_res : predicted);
  endtask

  // drain every pending result, then give the sequencer time to go quiet
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic run_phase(input phase_kind_t kind, input int count);
    bit burst;
    wait_idle();
    case (kind)
      PH_MAX: begin
        cfg_write(sapid_pkg::REG_KP, 32'h7FFF_FFFF);
        cfg_write(sapid_pkg::REG_KI, 32'h7FFF_FFFF);
        cfg_write(sapid_pkg::REG_KD, 32'h7FFF_FFFF);
        cfg_write(sapid_pkg::REG_BIAS, 32'h0000_7FFF);
        cfg_write(sapid_pkg::REG_TARGET, 32'h0000_3FFF);
      end
      PH_MIN: begin
        cfg_write(sapid_pkg::REG_KP, 32'h8000_0000);
        cfg_write(sapid_pkg::REG_KI, 32'h8000_0000);
        cfg_write(sapid_pkg::REG_KD, 32'h8000_0000);
        cfg_write(sapid_pkg::REG_BIAS, 32'hFFFF_8000);
        cfg_write(sapid_pkg::REG_TARGET, 32'h0000_4000);
      end
      PH_WIND_UP, PH_WIND_DOWN: begin
        cfg_write(sapid_pkg::REG_KP, rand_gain(1'b1));
        cfg_write(sapid_pkg::REG_KI, 32'($urandom_range(0, 128)) - 32'd64);
        cfg_write(sapid_pkg::REG_KD, rand_gain(1'b1));
        cfg_write(sapid_pkg::REG_BIAS, $urandom);
        // hold the target at or past a limit so the error stays at full scale
        if (kind == PH_WIND_UP) begin
          cfg_write(sapid_pkg::REG_TARGET, 32'($urandom_range(11520, 16383)));
        end else begin
          cfg_write(sapid_pkg::REG_TARGET, 32'($urandom_range(16384, 21248)));
        end
      end
      default: begin
        cfg_write(sapid_pkg::REG_KP, rand_gain(1'b0));
        cfg_write(sapid_pkg::REG_KI, rand_gain(1'b0));
        cfg_write(sapid_pkg::REG_KD, rand_gain(1'b0));
        cfg_write(sapid_pkg::REG_BIAS, $urandom);
        if ($urandom_range(0, 1)) begin
          cfg_write(sapid_pkg::REG_TARGET, 32'($urandom_range(0, 23040)) - 32'd11520);
        end else begin
          cfg_write(sapid_pkg::REG_TARGET, $urandom);
        end
      end
    endcase
    burst = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < count; n++) send_tick(pick_adc(kind), pick_gap(burst), 1'b0, NO_RES);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      ticks_done++;
      if (pending_ticks.size() == 0) begin
        flag_error($sformatf("result with no tick pending, drive %0d", drive));
      end else begin
        want = pending_ticks.pop_front();
        if (drive !== want.drive)
          flag_error($sformatf("tick %0d drive %0d, want %0d", ticks_done, drive, want.drive));
        if (measured_angle !== want.angle)
          flag_error($sformatf("tick %0d measured_angle %0d, want %0d",
                               ticks_done, measured_angle, want.angle));
        if (angle_error !== want.err)
          flag_error($sformatf("tick %0d angle_error %0d, want %0d",
                               ticks_done, angle_error, want.err));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL servo_angle_pid_step_core");
      $finish;
    end
  end

  initial begin : result_sink
    int r;
    int run;
    bit level;
    bit pressured;
    out_ready = 1'b0;
    pressured = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (!pressured && ticks_done >= 40) begin
        // hold off long enough for the core to back up into its input
        pressured = 1'b1;
        level     = 1'b0;
        run       = HOLD_OFF;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          level = 1'b1;
          run   = $urandom_range(1, 24);
        end else if (r < 88) begin
          level = 1'b0;
          run   = $urandom_range(1, 3);
        end else if (r < 97) begin
          level = 1'b0;
          run   = $urandom_range(4, 16);
        end else begin
          level = 1'b0;
          run   = $urandom_range(30, 90);
        end
      end
      @(negedge clk);
      out_ready = level;
      repeat (run - 1) @(negedge clk);
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    filtered_adc   = '0;
    cfg_valid      = 1'b0;
    cfg_index      = sapid_pkg::REG_KP;
    cfg_data       = '0;
    gain_p         = '0;
    gain_i         = '0;
    gain_d         = '0;
    bias_val       = '0;
    target_val     = '0;
    integ_state    = '0;
    err_state      = '0;
    ticks_done     = 0;
    mismatch_count = 0;
    stall_cycles   = 0;
    last_adc       = 12'd475;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        wait_idle();
        cfg_write(DIRECTED[i].idx, DIRECTED[i].val);
      end else begin
        send_tick(DIRECTED[i].val[sapid_pkg::ADC_WIDTH-1:0], pick_gap(1'b0),
                  DIRECTED[i].typed, DIRECTED[i].res);
      end
    end

    run_phase(PH_MIXED, 110);
    run_phase(PH_MAX, 50);
    run_phase(PH_MIN, 50);
    run_phase(PH_MIXED, 110);
    run_phase(PH_MIXED, 100);
    // push the integral hard upward, then drag it back down
    run_phase(PH_WIND_UP, 200);
    run_phase(PH_WIND_DOWN, 100);
    run_phase(PH_MIXED, 110);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS servo_angle_pid_step_core");
    end else begin
      $display("FAIL servo_angle_pid_step_core");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sapid_pkg.sv
hdl/sapid_ctrl.sv
hdl/sapid_dp.sv
hdl/servo_angle_pid_step_core.sv
bench/testbench.sv
